// ===== rtl/lpe_pkg.sv =====
// ============================================================================
// LED pixel encoder package
// Shared request types, codes and constants for the LED pixel PWM bit encoder.
// ============================================================================
`default_nettype none

package lpe_pkg;

    // Number of serialized color bits, and so the number of duty codes per pixel.
    localparam int unsigned BITS_PER_PIXEL = 24;
    localparam int unsigned CNT_W          = $clog2(BITS_PER_PIXEL);
    localparam int unsigned CHAN_W         = 8;
    localparam int unsigned COLOR_W        = 3 * CHAN_W;

    // Configuration register indexes.
    localparam logic CFG_DUTY_ONE  = 1'b0;
    localparam logic CFG_DUTY_ZERO = 1'b1;

    // Reset values of the duty registers.
    localparam logic [CHAN_W-1:0] DUTY_ONE_RST  = 8'd60;
    localparam logic [CHAN_W-1:0] DUTY_ZERO_RST = 8'd30;

    typedef struct packed {
        logic [COLOR_W-1:0] pixel_color;       // green 23..16, red 15..8, blue 7..0
        logic [CHAN_W-1:0]  pixel_brightness;  // 255 is full scale
    } t_pixel;

    typedef struct packed {
        logic [CHAN_W-1:0] duty_code;
        logic              last_bit;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/led_pixel_pwm_bit_encoder.sv =====
// ============================================================================
// LED pixel PWM bit encoder
// Scales a GRB pixel by its brightness and serializes it as 24 PWM duty codes.
// ============================================================================
//
//  Channel   Direction  Handshake              Payload
//  -------   ---------  ---------------------  ------------------------------
//  pixel     in         i_valid / o_stall      i_pixel  (color, brightness)
//  result    out        o_valid / i_stall      o_result (duty_code, last_bit)
//  config    in         i_cfg_we               i_cfg_index, i_cfg_data
//
//  A pixel leaves the result port as 24 duty codes from the bit shifter that feeds
//  the output register, one per cycle unless the output stalls. A pixel passes the
//  input register, shifter and result register in turn; the next one waits in the
//  input register while the previous one shifts out, and moves on as the last bit
//  leaves. Reset is synchronous and active low; it clears all valid flags and sets
//  the duty registers to 60 and 30. A stall while a code is held freezes the
//  shifter and result register; the input stalls only when its register is full.
//
`default_nettype none

module led_pixel_pwm_bit_encoder
    import lpe_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,

    input  wire                 i_valid,
    output logic                o_stall,
    input  wire t_pixel         i_pixel,

    output logic                o_valid,
    input  wire                 i_stall,
    output t_result             o_result,

    input  wire                 i_cfg_we,
    input  wire                 i_cfg_index,
    input  wire [CHAN_W-1:0]    i_cfg_data
);

    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(BITS_PER_PIXEL - 1);

    // Configuration registers.
    logic [CHAN_W-1:0]  r_duty_one;
    logic [CHAN_W-1:0]  r_duty_zero;

    // Input register holds one accepted request.
    logic               r_in_valid;
    t_pixel             r_in_pix;

    // Shifter holds the scaled word and counts the bits already sent.
    logic               r_sh_valid;
    logic [COLOR_W-1:0] r_sh_word;
    logic [CNT_W-1:0]   r_sh_cnt;

    // Result register.
    logic               r_out_valid;
    t_result            r_out;

    logic [COLOR_W-1:0] w_scaled;
    logic               w_out_load;
    logic               w_emit;
    logic               w_sh_done;
    logic               w_load_sh;
    logic               w_in_accept;
    t_result            n_out;

    lpe_scaler u_scaler (
        .i_pixel (r_in_pix),
        .o_word  (w_scaled)
    );

    // The result register may take a new code when it is empty or being read.
    assign w_out_load  = !r_out_valid || !i_stall;
    assign w_emit      = r_sh_valid && w_out_load;
    assign w_sh_done   = w_emit && (r_sh_cnt == LAST_CNT);
    // The shifter reloads from a waiting pixel when it is empty or sending its final bit.
    assign w_load_sh   = r_in_valid && (!r_sh_valid || w_sh_done);
    assign o_stall     = r_in_valid && !w_load_sh;
    assign w_in_accept = i_valid && !o_stall;

    always_comb begin
        n_out.duty_code = r_sh_word[COLOR_W-1] ? r_duty_one : r_duty_zero;
        n_out.last_bit  = (r_sh_cnt == LAST_CNT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty_one  <= DUTY_ONE_RST;
            r_duty_zero <= DUTY_ZERO_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DUTY_ONE:  r_duty_one  <= i_cfg_data;
                CFG_DUTY_ZERO: r_duty_zero <= i_cfg_data;
                default:       r_duty_one  <= r_duty_one;
            endcase
        end
    end

    // Input stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_load_sh) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_pix <= i_pixel;
        end
    end

    // Bit shifter, most significant bit first.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sh_valid <= 1'b0;
            r_sh_cnt   <= '0;
        end else if (w_load_sh) begin
            r_sh_valid <= 1'b1;
            r_sh_cnt   <= '0;
        end else if (w_sh_done) begin
            r_sh_valid <= 1'b0;
            r_sh_cnt   <= '0;
        end else if (w_emit) begin
            r_sh_cnt   <= r_sh_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_sh) begin
            r_sh_word <= w_scaled;
        end else if (w_emit) begin
            r_sh_word <= {r_sh_word[COLOR_W-2:0], 1'b0};
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out <= n_out;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // The bit counter never runs past the last bit of a pixel.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sh_valid |-> (r_sh_cnt <= LAST_CNT))
        else $error("bit counter out of range");

    // The shifter is never overwritten while it still has bits to send.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_sh |-> (!r_sh_valid || (w_emit && r_sh_cnt == LAST_CNT)))
        else $error("shifter reloaded in the middle of a pixel");

    // Two flagged codes can never be delivered back to back.
    a_last_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.last_bit && !i_stall) |=> !(o_valid && o_result.last_bit))
        else $error("last bit flagged twice in a row");

endmodule

`default_nettype wire

// ===== rtl/lpe_scaler.sv =====
// ============================================================================
// LED pixel brightness scaler
// Scales each color channel by brightness/255 with truncation and repacks GRB.
// ============================================================================
`default_nettype none

module lpe_scaler
    import lpe_pkg::*;
(
    input  wire t_pixel             i_pixel,
    output logic [COLOR_W-1:0]      o_word
);

    logic [CHAN_W-1:0]   w_chan  [3];
    logic [2*CHAN_W-1:0] w_prod  [3];
    logic [2*CHAN_W:0]   w_sum   [3];

    // floor(p/255) is exact as (p + (p >> 8) + 1) >> 8 for any product of two
    // 8-bit values.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_chan[i] = i_pixel.pixel_color[i*CHAN_W +: CHAN_W];
            w_prod[i] = {{CHAN_W{1'b0}}, w_chan[i]}
                      * {{CHAN_W{1'b0}}, i_pixel.pixel_brightness};
            w_sum[i]  = {1'b0, w_prod[i]}
                      + {{(CHAN_W+1){1'b0}}, w_prod[i][2*CHAN_W-1:CHAN_W]}
                      + {{(2*CHAN_W){1'b0}}, 1'b1};
            o_word[i*CHAN_W +: CHAN_W] = w_sum[i][2*CHAN_W-1:CHAN_W];
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/tb_led_pixel_pwm_bit_encoder.sv =====
`timescale 1ns / 100ps
// ============================================================================
// LED pixel PWM bit encoder testbench
// Sends pixels to the encoder under random idling on both channels and checks
// every duty code. The expected codes come from a local model of the
// brightness scaling and the MSB-first serializer.
// ============================================================================

module tb_led_pixel_pwm_bit_encoder;
    import lpe_pkg::*;

    // The receiver holds its stall once, so that the block backs up.
    localparam int unsigned HOLD_CYCLES    = 200;
    localparam int unsigned HOLD_AT_CODE   = 2000;
    // A request passes the input register, shifter and result register before its first code.
    localparam int unsigned DRAIN_CYCLES   = 4;
    localparam int unsigned WATCHDOG_LIMIT = 2000;

    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          i_valid     = 1'b0;
    logic          o_stall;
    t_pixel        i_pixel     = '0;
    logic          o_valid;
    logic          i_stall     = 1'b0;
    t_result       o_result;
    logic          i_cfg_we    = 1'b0;
    logic          i_cfg_index = CFG_DUTY_ONE;
    logic [CHAN_W-1:0] i_cfg_data = '0;

    // Pixels waiting to be offered, and the duty codes that the block owes us.
    t_pixel  pixel_q[$];
    t_result code_expect_q[$];

    // Local copy of the two duty registers, kept in step with every write.
    logic [CHAN_W-1:0] duty_one_now  = DUTY_ONE_RST;
    logic [CHAN_W-1:0] duty_zero_now = DUTY_ZERO_RST;

    int unsigned n_pixels_queued = 0;
    int unsigned n_pixels_in     = 0;
    int unsigned n_codes_out     = 0;
    int unsigned n_settings      = 1;
    int unsigned n_errors        = 0;
    bit          quiet_tail      = 1'b0;
    bit          hold_done       = 1'b0;
    int unsigned gap_left        = 0;
    int unsigned stall_left      = 0;
    int unsigned hold_left       = 0;
    int unsigned quiet_cycles    = 0;

    led_pixel_pwm_bit_encoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_pixel     (i_pixel),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Scales one channel by the brightness, truncating, so 255 leaves it as it is.
    function automatic logic [CHAN_W-1:0] dim_channel(input logic [CHAN_W-1:0] chan,
                                                      input logic [CHAN_W-1:0] bright);
        int unsigned prod;
        prod = int'(chan) * int'(bright);
        return CHAN_W'(prod / 255);
    endfunction

    // Works out the 24 duty codes of one pixel and appends them to the
    // expectation queue, most significant bit first; the last one is flagged.
    function automatic void push_pixel_codes(input t_pixel px);
        logic [COLOR_W-1:0] grb;
        t_result            code;
        grb = {dim_channel(px.pixel_color[23:16], px.pixel_brightness),
               dim_channel(px.pixel_color[15:8],  px.pixel_brightness),
               dim_channel(px.pixel_color[7:0],   px.pixel_brightness)};
        for (int k = COLOR_W - 1; k >= 0; k--) begin
            code.duty_code = grb[k] ? duty_one_now : duty_zero_now;
            code.last_bit  = (k == 0);
            code_expect_q.push_back(code);
        end
    endfunction

    function automatic t_pixel make_pixel(input logic [COLOR_W-1:0] color,
                                          input logic [CHAN_W-1:0] bright);
        t_pixel px;
        px.pixel_color      = color;
        px.pixel_brightness = bright;
        return px;
    endfunction

    // Random pixel that leans toward the dark, full and all-ones corners now
    // and then, while still reaching every bit of both fields.
    function automatic t_pixel random_pixel();
        logic [COLOR_W-1:0] color;
        logic [CHAN_W-1:0]  bright;
        case ($urandom_range(0, 9))
            0:       color = '0;
            1:       color = '1;
            default: color = COLOR_W'($urandom());
        endcase
        case ($urandom_range(0, 7))
            0:       bright = '0;
            1:       bright = '1;
            2:       bright = CHAN_W'($urandom_range(1, 3));
            default: bright = CHAN_W'($urandom_range(0, 255));
        endcase
        return make_pixel(color, bright);
    endfunction

    task automatic queue_pixel(input t_pixel px);
        pixel_q.push_back(px);
        n_pixels_queued++;
    endtask

    // Returns once every queued pixel has been taken and every code has come.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pixel_q.size() != 0 || n_pixels_in != n_pixels_queued ||
               code_expect_q.size() != 0);
    endtask

    // Writes both duty registers; the caller must make sure the block is idle, as the task does not wait for it.
    task automatic set_duties(input logic [CHAN_W-1:0] one, input logic [CHAN_W-1:0] zero);
        @(posedge i_clk);
        i_cfg_we      <= 1'b1;
        i_cfg_index   <= CFG_DUTY_ONE;
        i_cfg_data    <= one;
        duty_one_now  = one;
        @(posedge i_clk);
        i_cfg_index   <= CFG_DUTY_ZERO;
        i_cfg_data    <= zero;
        duty_zero_now = zero;
        @(posedge i_clk);
        i_cfg_we      <= 1'b0;
        n_settings++;
    endtask

    task automatic random_phase(input int unsigned count,
                                input logic [CHAN_W-1:0] one, input logic [CHAN_W-1:0] zero);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        set_duties(one, zero);
        repeat (count) queue_pixel(random_pixel());
    endtask

    // Sender. A request stays up until the block takes it; between requests it
    // sometimes drops valid for a short burst.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            gap_left = 0;
        end else begin
            if (i_valid && !o_stall) begin
                push_pixel_codes(i_pixel);
                n_pixels_in++;
            end
            // The payload may only move on once the current request is gone.
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pixel_q.size() > 0) begin
                    i_pixel <= pixel_q.pop_front();
                    i_valid <= 1'b1;
                    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                        gap_left = $urandom_range(1, 5);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver and checker. Every code taken is compared with the oldest one
    // still owed. Stall comes in short random bursts, plus one long hold that
    // lets the block fill up and push back on the sender.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                n_codes_out++;
                if (code_expect_q.size() == 0) begin
                    $error("unexpected duty code %0d (last_bit %0b)",
                           o_result.duty_code, o_result.last_bit);
                    n_errors++;
                end else begin
                    t_result want;
                    want = code_expect_q.pop_front();
                    if (o_result.duty_code !== want.duty_code) begin
                        $error("duty_code: expected %0d, got %0d",
                               want.duty_code, o_result.duty_code);
                        n_errors++;
                    end
                    if (o_result.last_bit !== want.last_bit) begin
                        $error("last_bit: expected %0b, got %0b",
                               want.last_bit, o_result.last_bit);
                        n_errors++;
                    end
                end
            end

            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (!hold_done && n_codes_out >= HOLD_AT_CODE) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                i_stall   <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 5) - 1;
                i_stall    <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog: ends the run if neither channel moves for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no request moved for %0d cycles, %0d codes still owed.",
                     WATCHDOG_LIMIT, code_expect_q.size());
            $display("** led_pixel_pwm_bit_encoder: FAILED **");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed pixels under the reset duty values: full and dark
        // brightness, single bits at the ends of the word, each channel alone,
        // alternating patterns and the truncation corners of the scaling.
        queue_pixel(make_pixel(24'hFFFFFF, 8'd255));
        queue_pixel(make_pixel(24'h000000, 8'd255));
        queue_pixel(make_pixel(24'hFFFFFF, 8'd0));
        queue_pixel(make_pixel(24'h800000, 8'd255));
        queue_pixel(make_pixel(24'h000001, 8'd255));
        queue_pixel(make_pixel(24'hFF0000, 8'd255));
        queue_pixel(make_pixel(24'h00FF00, 8'd255));
        queue_pixel(make_pixel(24'h0000FF, 8'd255));
        queue_pixel(make_pixel(24'hAA55AA, 8'd255));
        queue_pixel(make_pixel(24'h55AA55, 8'd255));
        queue_pixel(make_pixel(24'hFFFFFF, 8'd1));
        queue_pixel(make_pixel(24'hFFFFFF, 8'd128));
        queue_pixel(make_pixel(24'hFFFFFF, 8'd254));
        queue_pixel(make_pixel(24'h808080, 8'd254));
        queue_pixel(make_pixel(24'h010101, 8'd254));
        queue_pixel(make_pixel(24'h123456, 8'd200));
        queue_pixel(make_pixel(24'hFEDCBA, 8'd127));
        queue_pixel(make_pixel(24'h7F807F, 8'd2));

        // Random phases across the duty settings: both extremes, the swapped
        // pair, equal registers, and random values, the last one without idling.
        random_phase(120, 8'd255, 8'd0);
        random_phase(120, 8'd0, 8'd255);
        random_phase(60, 8'hA5, 8'hA5);
        random_phase(120, CHAN_W'($urandom_range(0, 255)), CHAN_W'($urandom_range(0, 255)));
        wait_drained();
        quiet_tail = 1'b1;
        random_phase(60, CHAN_W'($urandom_range(0, 255)), CHAN_W'($urandom_range(0, 255)));

        wait_drained();
        repeat (DRAIN_CYCLES * 2) @(posedge i_clk);
        if (code_expect_q.size() != 0) begin
            $error("%0d duty codes never arrived", code_expect_q.size());
            n_errors++;
        end

        $display("Sent %0d pixels and checked %0d duty codes under %0d duty settings,",
                 n_pixels_in, n_codes_out, n_settings);
        $display("with random idling, one long output hold and a final burst at full rate.");
        if (n_errors == 0) begin
            $display("** led_pixel_pwm_bit_encoder: PASSED **");
        end else begin
            $display("** led_pixel_pwm_bit_encoder: FAILED **");
        end
        $finish;
    end

endmodule
